// ===== hw/rtl/interval_set_membership_counter_assert.svh =====
// Assertion macros for the checker file of this block.
// Every assertion samples on the rising clock and is quiet while reset is held.
`ifndef INTERVAL_SET_MEMBERSHIP_COUNTER_ASSERT_SVH
`define INTERVAL_SET_MEMBERSHIP_COUNTER_ASSERT_SVH

// Implication written out in full by the caller.
`define ISMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition in one cycle, consequence in the next.
`define ISMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ismc_pkg.sv =====
package ismc_pkg;

    localparam int DEF_MAX_RANGES = 256;
    localparam int DEF_ID_BITS    = 48;

    // Width of the running hit count.
    localparam int COUNT_W = 32;

    // Result item: is_fresh, fresh_count, insert_dropped, padded to bytes.
    localparam int OUT_FIELDS_W = COUNT_W + 2;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FRESH    = 0;
    localparam int OUT_CNT_LO   = 1;
    localparam int OUT_DROP     = COUNT_W + 1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_Q_RD,
        S_Q_CHK,
        S_I_RD1,
        S_I_CHK1,
        S_I_RD2,
        S_I_CHK2,
        S_I_FIN,
        S_OUT
    } t_state;

    // Results of comparing one table entry against the key range [lo, hi].
    typedef struct packed {
        logic start_le_hi;
        logic lo_le_end;
        logic start_lt_lo;
        logic end_gt_hi;
    } t_cmp;

endpackage

// ===== hw/rtl/ismc_cmp.sv =====
module ismc_cmp #(
    parameter int ID_BITS = ismc_pkg::DEF_ID_BITS
) (
    input  logic [ID_BITS-1:0] i_ent_start,
    input  logic [ID_BITS-1:0] i_ent_end,
    input  logic [ID_BITS-1:0] i_key_lo,
    input  logic [ID_BITS-1:0] i_key_hi,
    output ismc_pkg::t_cmp     o_cmp
);

    // The one compare unit of the block, shared by query and both insert passes.
    always_comb begin
        o_cmp.start_le_hi = (i_ent_start <= i_key_hi);
        o_cmp.lo_le_end   = (i_key_lo <= i_ent_end);
        o_cmp.start_lt_lo = (i_ent_start < i_key_lo);
        o_cmp.end_gt_hi   = (i_ent_end > i_key_hi);
    end

endmodule

// ===== hw/rtl/ismc_table.sv =====
module ismc_table #(
    parameter int ID_BITS    = ismc_pkg::DEF_ID_BITS,
    parameter int MAX_RANGES = ismc_pkg::DEF_MAX_RANGES,
    localparam int IDX_W     = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_addr,
    input  logic [ID_BITS-1:0] i_wr_start,
    input  logic [ID_BITS-1:0] i_wr_end,
    input  logic [IDX_W-1:0]   i_rd_addr,
    output logic [ID_BITS-1:0] o_rd_start,
    output logic [ID_BITS-1:0] o_rd_end
);

    logic [ID_BITS-1:0] r_mem_start [MAX_RANGES];
    logic [ID_BITS-1:0] r_mem_end   [MAX_RANGES];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_start[i_wr_addr] <= i_wr_start;
            r_mem_end[i_wr_addr]   <= i_wr_end;
        end
        o_rd_start <= r_mem_start[i_rd_addr];
        o_rd_end   <= r_mem_end[i_rd_addr];
    end

endmodule

// ===== hw/rtl/interval_set_membership_counter.sv =====
// Interval set membership counter.
// The block holds up to MAX_RANGES inclusive ID ranges, sorted by start and
// free of overlaps. Commands arrive on the s_axis channel: tuser selects an
// insert (0) or a query (1), tdata carries range start, range end and query ID.
// Every command gives one item on the m_axis channel with the hit flag, the
// saturating hit count and the table-full drop flag.
// The block takes one command at a time: s_axis_tready is high only while it
// is idle. A query scans the stored entries in order until a hit, an entry
// that starts above the query ID, or the last entry. An insert runs a merge
// pass and a rewrite pass over the table, each reading one entry and then
// comparing it; an insert dropped for a full table ends after the merge pass.
// The pace is set by the single memory read port and the shared compare unit.
// The result is held in the output register until the receiver takes it; no
// new command is accepted meanwhile. Synchronous reset empties the table and
// clears the hit count; the memory itself is not cleared, as only entries
// below the fill count are ever read.
module interval_set_membership_counter #(
    parameter int MAX_RANGES = ismc_pkg::DEF_MAX_RANGES,
    parameter int ID_BITS    = ismc_pkg::DEF_ID_BITS,
    localparam int IN_W      = ((3 * ID_BITS + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // range_start, range_end, query_id from the lowest bit up.
    input  logic [IN_W-1:0]            s_axis_tdata,
    // cmd.
    input  logic                       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // is_fresh, fresh_count, insert_dropped from the lowest bit up.
    output logic [ismc_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int IDX_W   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W   = $clog2(MAX_RANGES + 1);
    localparam int COUNT_W = ismc_pkg::COUNT_W;

    // Input fields as they stand on the bus.
    logic [ID_BITS-1:0] in_start;
    logic [ID_BITS-1:0] in_end;
    logic [ID_BITS-1:0] in_qid;
    logic               in_acc;

    assign in_start = s_axis_tdata[ID_BITS-1:0];
    assign in_end   = s_axis_tdata[2*ID_BITS-1:ID_BITS];
    assign in_qid   = s_axis_tdata[3*ID_BITS-1:2*ID_BITS];
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    ismc_pkg::t_state r_state, n_state;

    // Key range: the range being merged for an insert, or the query ID twice.
    logic [ID_BITS-1:0] r_lo, n_lo;
    logic [ID_BITS-1:0] r_hi, n_hi;
    // Scan index, rewrite pointer and table fill count.
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_wptr, n_wptr;
    logic [CNT_W-1:0]   r_count, n_count;
    // Merge pass saw an overlap; rewrite pass has placed the merged range;
    // a displaced entry waits in the carry register.
    logic               r_any, n_any;
    logic               r_placed, n_placed;
    logic               r_cv, n_cv;
    logic [ID_BITS-1:0] r_carry_start, n_carry_start;
    logic [ID_BITS-1:0] r_carry_end, n_carry_end;
    // Result fields.
    logic [COUNT_W-1:0] r_hits, n_hits;
    logic               r_is_fresh, n_is_fresh;
    logic               r_dropped, n_dropped;

    // Table ports.
    logic               wr_en;
    logic [ID_BITS-1:0] wr_start;
    logic [ID_BITS-1:0] wr_end;
    logic [ID_BITS-1:0] rd_start;
    logic [ID_BITS-1:0] rd_end;

    ismc_pkg::t_cmp     cmp;
    logic               ovl;
    logic               last;
    logic               full;

    ismc_table #(
        .ID_BITS    (ID_BITS),
        .MAX_RANGES (MAX_RANGES)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_wptr[IDX_W-1:0]),
        .i_wr_start (wr_start),
        .i_wr_end   (wr_end),
        .i_rd_addr  (r_idx[IDX_W-1:0]),
        .o_rd_start (rd_start),
        .o_rd_end   (rd_end)
    );

    ismc_cmp #(
        .ID_BITS     (ID_BITS)
    ) u_cmp (
        .i_ent_start (rd_start),
        .i_ent_end   (rd_end),
        .i_key_lo    (r_lo),
        .i_key_hi    (r_hi),
        .o_cmp       (cmp)
    );

    assign ovl  = cmp.start_le_hi && cmp.lo_le_end;
    assign last = ((r_idx + CNT_W'(1)) == r_count);
    assign full = (r_count == CNT_W'(MAX_RANGES));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ismc_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == ismc_pkg::CMD_QUERY) begin
                        n_state = (r_count == '0) ? ismc_pkg::S_OUT : ismc_pkg::S_Q_RD;
                    end else if (in_start > in_end) begin
                        n_state = ismc_pkg::S_OUT;
                    end else begin
                        n_state = (r_count == '0) ? ismc_pkg::S_I_FIN : ismc_pkg::S_I_RD1;
                    end
                end
            end
            ismc_pkg::S_Q_RD: begin
                n_state = ismc_pkg::S_Q_CHK;
            end
            ismc_pkg::S_Q_CHK: begin
                if (!cmp.start_le_hi || cmp.lo_le_end || last) begin
                    n_state = ismc_pkg::S_OUT;
                end else begin
                    n_state = ismc_pkg::S_Q_RD;
                end
            end
            ismc_pkg::S_I_RD1: begin
                n_state = ismc_pkg::S_I_CHK1;
            end
            ismc_pkg::S_I_CHK1: begin
                if (!last) begin
                    n_state = ismc_pkg::S_I_RD1;
                end else if (!(r_any || ovl) && full) begin
                    n_state = ismc_pkg::S_OUT;
                end else begin
                    n_state = ismc_pkg::S_I_RD2;
                end
            end
            ismc_pkg::S_I_RD2: begin
                n_state = ismc_pkg::S_I_CHK2;
            end
            ismc_pkg::S_I_CHK2: begin
                n_state = last ? ismc_pkg::S_I_FIN : ismc_pkg::S_I_RD2;
            end
            ismc_pkg::S_I_FIN: begin
                n_state = ismc_pkg::S_OUT;
            end
            ismc_pkg::S_OUT: begin
                if (m_axis_tready) begin
                    n_state = ismc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ismc_pkg::S_IDLE;
            end
        endcase
    end

    // Handshake and table write controls.
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        wr_en         = 1'b0;
        wr_start      = r_lo;
        wr_end        = r_hi;
        unique case (r_state) inside
            ismc_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ismc_pkg::S_OUT: begin
                m_axis_tvalid = 1'b1;
            end
            ismc_pkg::S_I_CHK2: begin
                if (ovl) begin
                    // First absorbed entry: the merged range takes its place.
                    wr_en = !r_placed;
                end else if (r_cv) begin
                    wr_en    = 1'b1;
                    wr_start = r_carry_start;
                    wr_end   = r_carry_end;
                end else if (!r_placed && !cmp.start_lt_lo) begin
                    wr_en = 1'b1;
                end else begin
                    wr_en    = 1'b1;
                    wr_start = rd_start;
                    wr_end   = rd_end;
                end
            end
            ismc_pkg::S_I_FIN: begin
                if (r_cv) begin
                    wr_en    = 1'b1;
                    wr_start = r_carry_start;
                    wr_end   = r_carry_end;
                end else begin
                    wr_en = !r_placed;
                end
            end
            ismc_pkg::S_Q_RD, ismc_pkg::S_Q_CHK, ismc_pkg::S_I_RD1,
            ismc_pkg::S_I_CHK1, ismc_pkg::S_I_RD2: begin
                wr_en = 1'b0;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_idx         = r_idx;
        n_wptr        = r_wptr;
        n_count       = r_count;
        n_any         = r_any;
        n_placed      = r_placed;
        n_cv          = r_cv;
        n_carry_start = r_carry_start;
        n_carry_end   = r_carry_end;
        n_hits        = r_hits;
        n_is_fresh    = r_is_fresh;
        n_dropped     = r_dropped;
        case (r_state)
            ismc_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_lo       = (s_axis_tuser == ismc_pkg::CMD_QUERY) ? in_qid : in_start;
                    n_hi       = (s_axis_tuser == ismc_pkg::CMD_QUERY) ? in_qid : in_end;
                    n_idx      = '0;
                    n_wptr     = '0;
                    n_any      = 1'b0;
                    n_placed   = 1'b0;
                    n_cv       = 1'b0;
                    n_is_fresh = 1'b0;
                    n_dropped  = 1'b0;
                end
            end
            ismc_pkg::S_Q_CHK: begin
                if (!cmp.start_le_hi) begin
                    n_is_fresh = 1'b0;
                end else if (cmp.lo_le_end) begin
                    n_is_fresh = 1'b1;
                    if (r_hits != {COUNT_W{1'b1}}) begin
                        n_hits = r_hits + COUNT_W'(1);
                    end
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            ismc_pkg::S_I_CHK1: begin
                // Widen the key range by every entry that overlaps it.
                if (ovl) begin
                    n_any = 1'b1;
                    if (cmp.start_lt_lo) begin
                        n_lo = rd_start;
                    end
                    if (cmp.end_gt_hi) begin
                        n_hi = rd_end;
                    end
                end
                if (last) begin
                    n_idx     = '0;
                    n_dropped = !(r_any || ovl) && full;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            ismc_pkg::S_I_CHK2: begin
                n_idx = r_idx + CNT_W'(1);
                if (ovl) begin
                    if (!r_placed) begin
                        n_wptr   = r_wptr + CNT_W'(1);
                        n_placed = 1'b1;
                    end
                end else if (r_cv) begin
                    // Entries after an inserted range move up by one place.
                    n_wptr        = r_wptr + CNT_W'(1);
                    n_carry_start = rd_start;
                    n_carry_end   = rd_end;
                end else if (!r_placed && !cmp.start_lt_lo) begin
                    n_wptr        = r_wptr + CNT_W'(1);
                    n_placed      = 1'b1;
                    n_cv          = 1'b1;
                    n_carry_start = rd_start;
                    n_carry_end   = rd_end;
                end else begin
                    n_wptr = r_wptr + CNT_W'(1);
                end
            end
            ismc_pkg::S_I_FIN: begin
                n_count = (r_cv || !r_placed) ? (r_wptr + CNT_W'(1)) : r_wptr;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ismc_pkg::S_IDLE;
            r_count  <= '0;
            r_hits   <= '0;
            r_idx    <= '0;
            r_wptr   <= '0;
            r_any    <= 1'b0;
            r_placed <= 1'b0;
            r_cv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_hits   <= n_hits;
            r_idx    <= n_idx;
            r_wptr   <= n_wptr;
            r_any    <= n_any;
            r_placed <= n_placed;
            r_cv     <= n_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_carry_start <= n_carry_start;
        r_carry_end   <= n_carry_end;
        r_is_fresh    <= n_is_fresh;
        r_dropped     <= n_dropped;
    end

    always_comb begin
        m_axis_tdata                                            = '0;
        m_axis_tdata[ismc_pkg::OUT_FRESH]                       = r_is_fresh;
        m_axis_tdata[ismc_pkg::OUT_CNT_LO +: COUNT_W]           = r_hits;
        m_axis_tdata[ismc_pkg::OUT_DROP]                        = r_dropped;
    end

endmodule

// ===== hw/rtl/ismc_checker.sv =====
`include "interval_set_membership_counter_assert.svh"

module ismc_checker #(
    parameter int ID_BITS = ismc_pkg::DEF_ID_BITS,
    localparam int IN_W   = ((3 * ID_BITS + 7) / 8) * 8
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [IN_W-1:0]            s_axis_tdata,
    input logic                       s_axis_tuser,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [ismc_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int COUNT_W = ismc_pkg::COUNT_W;

    logic [COUNT_W-1:0] r_last_cnt;
    logic [COUNT_W-1:0] exp_cnt;
    logic [COUNT_W-1:0] out_cnt;
    logic               out_fresh;
    logic               out_drop;
    logic               in_seen;

    assign out_cnt   = m_axis_tdata[ismc_pkg::OUT_CNT_LO +: COUNT_W];
    assign out_fresh = m_axis_tdata[ismc_pkg::OUT_FRESH];
    assign out_drop  = m_axis_tdata[ismc_pkg::OUT_DROP];
    assign in_seen   = s_axis_tvalid && (s_axis_tdata != '0 || s_axis_tuser);

    // Count of the last delivered item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cnt <= '0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_last_cnt <= out_cnt;
        end
    end

    always_comb begin
        exp_cnt = r_last_cnt;
        if (out_fresh && (r_last_cnt != {COUNT_W{1'b1}})) begin
            exp_cnt = r_last_cnt + COUNT_W'(1);
        end
    end

    `ISMC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `ISMC_ASSERT(a_one_at_a_time, m_axis_tvalid |-> !s_axis_tready,
        "command accepted while a result is pending")
    `ISMC_ASSERT(a_flags_excl, m_axis_tvalid |-> !(out_fresh && out_drop),
        "hit and drop flagged in one result")
    `ISMC_ASSERT(a_count_step, $rose(m_axis_tvalid) |-> (out_cnt == exp_cnt),
        "hit count moved other than by one fresh query")
    `ISMC_ASSERT_NEXT(a_busy_after_cmd, in_seen && s_axis_tready, !s_axis_tready,
        "ready stayed high after a command was taken")

endmodule

bind interval_set_membership_counter ismc_checker #(.ID_BITS(ID_BITS)) u_ismc_checker (.*);
